// File: rtl/worst_m_partition_replace_macros.svh
// Assertion helpers for the worst_m_partition_replace module.
`ifndef WORST_M_PARTITION_REPLACE_MACROS_SVH
`define WORST_M_PARTITION_REPLACE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define WMPR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define WMPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/wmpr_pkg.sv
package wmpr_pkg;

    localparam int MAX_POP  = 256;
    localparam int TAG_BITS = 16;
    localparam int FIT_BITS = 32;

    localparam int ADDR_W    = $clog2(MAX_POP);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int IDX_W     = CNT_W + 1;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam int IN_DATA_W  = ((FIT_BITS + TAG_BITS + ADDR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ADDR_W + FIT_BITS + TAG_BITS + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PART   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_READY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POP_SIZE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_COUNT = 1'd1;

    localparam logic signed [IDX_W-1:0] IDX_ONE = IDX_W'(1);

    typedef struct packed {
        logic [FIT_BITS-1:0] fit;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

    typedef struct packed {
        logic gt;
        logic lt;
    } cmp_res_t;

endpackage

// File: rtl/wmpr_store.sv
module wmpr_store
    import wmpr_pkg::*;
(
    input  logic              clk,
    input  mem_wr_t           wr,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t store_mem [MAX_POP];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= store_mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// File: rtl/wmpr_mid_cmp.sv
module wmpr_mid_cmp
    import wmpr_pkg::*;
(
    input  logic [FIT_BITS-1:0] fit,
    input  logic [FIT_BITS:0]   pivot_sum,
    output cmp_res_t            res
);

    // Twice the fitness is exact in one extra bit, as is the sum of the ends.
    logic [FIT_BITS:0] twice;

    assign twice  = {fit, 1'b0};
    assign res.gt = $signed(twice) > $signed(pivot_sum);
    assign res.lt = $signed(twice) < $signed(pivot_sum);

endmodule

// File: rtl/worst_m_partition_replace.sv
// Population store with worst-portion replacement.
// One request enters on the s_axis channel (kind in tuser) and gives one result
// on the m_axis channel (status in tuser). Loads fill slots in order; a partition
// on a full store moves the replace_count lowest-fitness entries to the top slots;
// inserts then overwrite those slots in order; reads return any slot in use.
// Loads, partitions that are refused or skipped, and refused inserts or reads go
// from transfer straight to the result state; accepted inserts and reads pass
// first through a wait state for the registered read of the store.
// A partition pass fetches the ends and forms the pivot, then scans entries and
// swaps them, all through the one store read port and the one midpoint
// comparator; the number of passes depends on the data.
// The input is not ready while a request is in progress.
// Reset sets the counters, flags, state and config to defaults, not most datapath
// registers; store contents are undefined until loaded and get no clearing pass.
// A result waits in the output register while the receiver stalls; the next request
// is still taken, and its result waits until the output register is free.
`include "worst_m_partition_replace_macros.svh"

module worst_m_partition_replace
    import wmpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // fitness, tag, slot
    input  logic [REQ_W-1:0]      s_axis_tuser,  // req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // slot_index, out_fitness, out_tag
    output logic [STAT_W-1:0]     m_axis_tuser   // status
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_INS     = 17'b00000000000000010,
        S_RDW     = 17'b00000000000000100,
        S_RESP    = 17'b00000000000001000,
        S_P_START = 17'b00000000000010000,
        S_P_ENDA  = 17'b00000000000100000,
        S_P_ENDB  = 17'b00000000001000000,
        S_P_OUTER = 17'b00000000010000000,
        S_L_CHK   = 17'b00000000100000000,
        S_L_CMP   = 17'b00000001000000000,
        S_R_CHK   = 17'b00000010000000000,
        S_R_CMP   = 17'b00000100000000000,
        S_SW_CHK  = 17'b00001000000000000,
        S_SW_RDL  = 17'b00010000000000000,
        S_SW_RDR  = 17'b00100000000000000,
        S_SW_WR   = 17'b01000000000000000,
        S_P_END   = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] pop_size_reg, replace_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] ins_reg, ins_next;
    logic [CNT_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic             part_reg, part_next;

    logic signed [IDX_W-1:0] lo_reg, lo_next;
    logic signed [IDX_W-1:0] hi_reg, hi_next;
    logic signed [IDX_W-1:0] l_reg, l_next;
    logic signed [IDX_W-1:0] r_reg, r_next;

    logic [FIT_BITS-1:0] pa_reg, pa_next;
    logic [FIT_BITS:0]   sum_reg, sum_next;
    entry_t              swap_reg, swap_next;
    logic [FIT_BITS-1:0] in_fit_reg, in_fit_next;
    logic [TAG_BITS-1:0] in_tag_reg, in_tag_next;

    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_idx_reg, res_idx_next;
    logic [FIT_BITS-1:0] res_fit_reg, res_fit_next;
    logic [TAG_BITS-1:0] res_tag_reg, res_tag_next;

    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   out_status_reg;
    logic [ADDR_W-1:0]   out_idx_reg;
    logic [FIT_BITS-1:0] out_fit_reg;
    logic [TAG_BITS-1:0] out_tag_reg;

    logic                s_accept, out_free, out_load;
    logic [REQ_W-1:0]    in_req;
    logic [FIT_BITS-1:0] in_fit;
    logic [TAG_BITS-1:0] in_tag;
    logic [ADDR_W-1:0]   in_slot;

    logic [CNT_W-1:0]        pop, m_cnt, base_calc;
    logic [ADDR_W-1:0]       ins_addr;
    logic signed [IDX_W-1:0] bound;

    mem_wr_t           wr;
    logic [ADDR_W-1:0] raddr;
    entry_t            rdata;
    cmp_res_t          cmp;

    wmpr_store u_store (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    wmpr_mid_cmp u_cmp (
        .fit       (rdata.fit),
        .pivot_sum (sum_reg),
        .res       (cmp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == S_RESP) && out_free;

    assign in_req  = s_axis_tuser;
    assign in_fit  = s_axis_tdata[FIT_BITS-1:0];
    assign in_tag  = s_axis_tdata[FIT_BITS +: TAG_BITS];
    assign in_slot = s_axis_tdata[FIT_BITS + TAG_BITS +: ADDR_W];

    always_comb
    begin
        if (pop_size_reg < CFG_W'(2))
        begin
            pop = CNT_W'(2);
        end
        else if (int'(pop_size_reg) > MAX_POP)
        begin
            pop = CNT_W'(MAX_POP);
        end
        else
        begin
            pop = CNT_W'(pop_size_reg);
        end
    end

    assign m_cnt     = CNT_W'(replace_reg);
    assign base_calc = pop - m_cnt;
    assign ins_addr  = ADDR_W'(base_reg + ins_reg);
    assign bound     = $signed({1'b0, base_reg});

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        ins_next        = ins_reg;
        base_next       = base_reg;
        total_next      = total_reg;
        part_next       = part_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        pa_next         = pa_reg;
        sum_next        = sum_reg;
        swap_next       = swap_reg;
        in_fit_next     = in_fit_reg;
        in_tag_next     = in_tag_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_fit_next    = res_fit_reg;
        res_tag_next    = res_tag_reg;
        wr              = '0;
        raddr           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    in_fit_next     = in_fit;
                    in_tag_next     = in_tag;
                    res_status_next = STAT_OK;
                    res_idx_next    = '0;
                    res_fit_next    = '0;
                    res_tag_next    = '0;
                    state_next      = S_RESP;
                    case (in_req)
                        REQ_LOAD:
                        begin
                            if (fill_reg >= pop)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr.en        = 1'b1;
                                wr.addr      = fill_reg[ADDR_W-1:0];
                                wr.data.fit  = in_fit;
                                wr.data.tag  = in_tag;
                                res_idx_next = fill_reg[ADDR_W-1:0];
                                res_fit_next = in_fit;
                                res_tag_next = in_tag;
                                fill_next    = fill_reg + CNT_W'(1);
                                part_next    = 1'b0;
                            end
                        end
                        REQ_PART:
                        begin
                            if (fill_reg < pop)
                            begin
                                res_status_next = STAT_NOT_READY;
                            end
                            else
                            begin
                                part_next = 1'b1;
                                ins_next  = '0;
                                if (int'(replace_reg) >= int'(pop))
                                begin
                                    base_next    = '0;
                                    total_next   = pop;
                                    res_idx_next = '0;
                                end
                                else if (replace_reg == '0)
                                begin
                                    base_next    = pop;
                                    total_next   = '0;
                                    res_idx_next = pop[ADDR_W-1:0];
                                end
                                else
                                begin
                                    base_next    = base_calc;
                                    total_next   = m_cnt;
                                    res_idx_next = base_calc[ADDR_W-1:0];
                                    lo_next      = '0;
                                    hi_next      = $signed({1'b0, pop}) - IDX_ONE;
                                    state_next   = S_P_START;
                                end
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (!part_reg)
                            begin
                                res_status_next = STAT_NOT_READY;
                            end
                            else if (ins_reg >= total_reg)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                raddr        = ins_addr;
                                res_idx_next = ins_addr;
                                state_next   = S_INS;
                            end
                        end
                        REQ_READ:
                        begin
                            if (CNT_W'(in_slot) >= pop)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                raddr        = in_slot;
                                res_idx_next = in_slot;
                                state_next   = S_RDW;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_FULL;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                wr.en        = 1'b1;
                wr.addr      = ins_addr;
                wr.data.fit  = in_fit_reg;
                wr.data.tag  = in_tag_reg;
                res_fit_next = in_fit_reg;
                res_tag_next = rdata.tag;
                ins_next     = ins_reg + CNT_W'(1);
                state_next   = S_RESP;
            end
            S_RDW:
            begin
                res_fit_next = rdata.fit;
                res_tag_next = rdata.tag;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_P_START:
            begin
                raddr      = lo_reg[ADDR_W-1:0];
                state_next = S_P_ENDA;
            end
            S_P_ENDA:
            begin
                pa_next    = rdata.fit;
                raddr      = hi_reg[ADDR_W-1:0];
                state_next = S_P_ENDB;
            end
            S_P_ENDB:
            begin
                sum_next   = {pa_reg[FIT_BITS-1], pa_reg} + {rdata.fit[FIT_BITS-1], rdata.fit};
                l_next     = lo_reg;
                r_next     = hi_reg;
                state_next = S_P_OUTER;
            end
            S_P_OUTER:
            begin
                if (l_reg <= r_reg)
                begin
                    state_next = S_L_CHK;
                end
                else
                begin
                    state_next = S_P_END;
                end
            end
            S_L_CHK:
            begin
                if (l_reg < hi_reg)
                begin
                    raddr      = l_reg[ADDR_W-1:0];
                    state_next = S_L_CMP;
                end
                else
                begin
                    state_next = S_R_CHK;
                end
            end
            S_L_CMP:
            begin
                if (cmp.gt)
                begin
                    l_next     = l_reg + IDX_ONE;
                    state_next = S_L_CHK;
                end
                else
                begin
                    state_next = S_R_CHK;
                end
            end
            S_R_CHK:
            begin
                if (r_reg > lo_reg)
                begin
                    raddr      = r_reg[ADDR_W-1:0];
                    state_next = S_R_CMP;
                end
                else
                begin
                    state_next = S_SW_CHK;
                end
            end
            S_R_CMP:
            begin
                if (cmp.lt)
                begin
                    r_next     = r_reg - IDX_ONE;
                    state_next = S_R_CHK;
                end
                else
                begin
                    state_next = S_SW_CHK;
                end
            end
            S_SW_CHK:
            begin
                if (l_reg < r_reg)
                begin
                    raddr      = l_reg[ADDR_W-1:0];
                    state_next = S_SW_RDL;
                end
                else if (l_reg == r_reg)
                begin
                    l_next     = l_reg + IDX_ONE;
                    r_next     = r_reg - IDX_ONE;
                    state_next = S_P_OUTER;
                end
                else
                begin
                    state_next = S_P_OUTER;
                end
            end
            S_SW_RDL:
            begin
                swap_next  = rdata;
                raddr      = r_reg[ADDR_W-1:0];
                state_next = S_SW_RDR;
            end
            S_SW_RDR:
            begin
                wr.en      = 1'b1;
                wr.addr    = l_reg[ADDR_W-1:0];
                wr.data    = rdata;
                state_next = S_SW_WR;
            end
            S_SW_WR:
            begin
                wr.en      = 1'b1;
                wr.addr    = r_reg[ADDR_W-1:0];
                wr.data    = swap_reg;
                l_next     = l_reg + IDX_ONE;
                r_next     = r_reg - IDX_ONE;
                state_next = S_P_OUTER;
            end
            S_P_END:
            begin
                if ((l_reg == bound) || (r_reg == bound - IDX_ONE))
                begin
                    state_next = S_RESP;
                end
                else if ((r_reg >= bound) && (lo_reg < r_reg))
                begin
                    hi_next    = r_reg;
                    state_next = S_P_START;
                end
                else if ((l_reg < bound) && (l_reg < hi_reg))
                begin
                    lo_next    = l_reg;
                    state_next = S_P_START;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pop_size_reg  <= CFG_W'(256);
            replace_reg   <= CFG_W'(1);
            fill_reg      <= '0;
            ins_reg       <= '0;
            base_reg      <= '0;
            total_reg     <= '0;
            part_reg      <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ins_reg       <= ins_next;
            base_reg      <= base_next;
            total_reg     <= total_next;
            part_reg      <= part_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POP_SIZE:      pop_size_reg <= cfg_data;
                    CFG_REPLACE_COUNT: replace_reg  <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg          <= l_next;
        r_reg          <= r_next;
        pa_reg         <= pa_next;
        sum_reg        <= sum_next;
        swap_reg       <= swap_next;
        in_fit_reg     <= in_fit_next;
        in_tag_reg     <= in_tag_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_fit_reg    <= res_fit_next;
        res_tag_reg    <= res_tag_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_reg;
            out_fit_reg    <= res_fit_reg;
            out_tag_reg    <= res_tag_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_tag_reg, out_fit_reg, out_idx_reg});

    `WMPR_ASSERT_NEXT(a_busy_after_transfer, s_accept, !s_axis_tready)
    `WMPR_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= CNT_W'(MAX_POP))
    `WMPR_ASSERT_IMPL(a_insert_bound, 1'b1, ins_reg <= total_reg)
    `WMPR_ASSERT_IMPL(a_left_scan_range, state_reg == S_L_CMP, (l_reg >= lo_reg) && (l_reg < hi_reg))
    `WMPR_ASSERT_IMPL(a_swap_order, state_reg == S_SW_WR, l_reg < r_reg)

endmodule
